>>> design/hfd_pkg.sv
// Shared types, constants and functions for the humidity/temperature frame decoder.
package hfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_MSB     = 8'h80;

    localparam logic [2:0]  POS_T_HI    = 3'd0;
    localparam logic [2:0]  POS_T_LO    = 3'd1;
    localparam logic [2:0]  POS_T_CRC   = 3'd2;
    localparam logic [2:0]  POS_H_HI    = 3'd3;
    localparam logic [2:0]  POS_H_LO    = 3'd4;
    localparam logic [2:0]  POS_H_CRC   = 3'd5;

    localparam int          QUEUE_DEPTH = 2;

    localparam int          TPROD_W     = 34;
    localparam int          HPROD_W     = 33;
    localparam logic [17:0] TEMP_SCALE  = 18'd175000;
    localparam logic [16:0] HUM_SCALE   = 17'd100000;
    localparam logic [17:0] TEMP_OFFSET = 18'd45000;
    localparam logic [15:0] DIV_CONST   = 16'hFFFF;

    typedef struct packed {
        logic        good;
        logic [15:0] temperature_code;
        logic [15:0] humidity_code;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^34, by folding the high half back twice
    function automatic logic [17:0] div_65535(input logic [TPROD_W-1:0] x);
        logic [17:0] q1;
        logic [18:0] r1;
        logic [2:0]  q2;
        logic [16:0] r2;
        logic        q3;
        q1 = x[TPROD_W-1:16];
        r1 = 19'(x[15:0]) + 19'(q1);
        q2 = r1[18:16];
        r2 = 17'(r1[15:0]) + 17'(q2);
        q3 = (r2 >= 17'(DIV_CONST));
        return q1 + 18'(q2) + 18'(q3);
    endfunction

endpackage

>>> design/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature sensor frame decoder.
// Accepts one response byte per cycle (s_tready drops only when the two-record queue is
// full) and returns one result per six-byte frame. With the back end idle, the record
// enters the queue on the edge that accepts the last byte, the constant multiplies are
// registered from the queue head, and the divide-by-65535 fold then loads the result
// register that drives m_tvalid. Each frame is the temperature word, its CRC-8
// (poly 0x31, init 0xFF), the humidity word and its CRC; s_tuser marks the
// first byte. A CRC error reports status 1 and keeps the last good readings.
module humidity_temp_frame_decoder #(
    parameter int QUEUE_DEPTH = hfd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] status, [18:1] temperature_milli_c,
                                   // [35:19] humidity_milli_pct, [51:36] temperature_code,
                                   // [67:52] humidity_code, [71:68] zero
);

    hfd_pkg::frame_rec_t  push_rec, pop_rec;
    hfd_pkg::queue_stat_t q_stat;
    logic                 push, pop, s_accept;

    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    hfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser[0]),
        .push        (push),
        .push_rec    (push_rec)
    );

    hfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .stat     (q_stat)
    );

    hfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (!q_stat.empty),
        .rec       (pop_rec),
        .rec_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("frame record pushed into a full queue");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:19] <= 17'd100000))
        else $error("humidity out of range");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71:68] == 4'h0))
        else $error("result padding not zero");

endmodule

>>> design/hfd_front.sv
// Front end: byte position tracking, CRC check and word assembly; emits one record per frame.
module hfd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                push,
    output hfd_pkg::frame_rec_t push_rec
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] word_reg, word_next;
    logic [15:0] held_reg, held_next;
    logic        fgood_reg, fgood_next;
    logic [2:0]  pos;

    assign pos = frame_start ? hfd_pkg::POS_T_HI : pos_reg;

    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        word_next  = word_reg;
        held_next  = held_reg;
        fgood_next = fgood_reg;
        push       = 1'b0;
        push_rec.good             = fgood_reg && (crc_reg == rx_byte);
        push_rec.temperature_code = held_reg;
        push_rec.humidity_code    = word_reg;
        if (accept) begin
            pos_next = pos + 3'd1;
            case (pos)
                hfd_pkg::POS_T_HI, hfd_pkg::POS_H_HI: begin
                    crc_next  = hfd_pkg::crc_update(hfd_pkg::CRC_INIT, rx_byte);
                    word_next = {rx_byte, 8'h00};
                end
                hfd_pkg::POS_T_LO, hfd_pkg::POS_H_LO: begin
                    crc_next  = hfd_pkg::crc_update(crc_reg, rx_byte);
                    word_next = {word_reg[15:8], rx_byte};
                end
                hfd_pkg::POS_T_CRC: begin
                    fgood_next = (crc_reg == rx_byte);
                    held_next  = word_reg;
                    crc_next   = hfd_pkg::CRC_INIT;
                end
                default: begin
                    push     = 1'b1;
                    crc_next = hfd_pkg::CRC_INIT;
                    pos_next = hfd_pkg::POS_T_HI;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= hfd_pkg::POS_T_HI;
            crc_reg   <= hfd_pkg::CRC_INIT;
            word_reg  <= 16'h0000;
            held_reg  <= 16'h0000;
            fgood_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            word_reg  <= word_next;
            held_reg  <= held_next;
            fgood_reg <= fgood_next;
        end
    end

endmodule

>>> design/hfd_queue.sv
// Short record queue between the front end and the conversion back end.
module hfd_queue #(
    parameter int DEPTH = hfd_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hfd_pkg::frame_rec_t  push_rec,
    input  logic                 pop,
    output hfd_pkg::frame_rec_t  pop_rec,
    output hfd_pkg::queue_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hfd_pkg::frame_rec_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_rec    = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/hfd_back.sv
// Back end: scale raw words, keep the last good readings and drive the result register.
module hfd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rec_valid,
    input  hfd_pkg::frame_rec_t rec,
    output logic                rec_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata
);

    logic                         a_valid_reg, a_valid_next;
    hfd_pkg::frame_rec_t          a_rec_reg;
    logic [hfd_pkg::TPROD_W-1:0]  a_tprod_reg;
    logic [hfd_pkg::HPROD_W-1:0]  a_hprod_reg;
    logic                         a_ready, out_load;

    logic                         m_valid_reg, m_valid_next;
    logic                         status_reg;
    logic [17:0]                  temp_reg, temp_next;
    logic [16:0]                  hum_reg, hum_next;
    logic [15:0]                  tcode_reg, hcode_reg;

    logic [17:0]                  tq, hq;

    assign out_load     = a_valid_reg && (!m_valid_reg || m_tready);
    assign a_ready      = !a_valid_reg || out_load;
    assign rec_pop      = rec_valid && a_ready;
    assign a_valid_next = rec_pop ? 1'b1 : (out_load ? 1'b0 : a_valid_reg);
    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    assign tq = hfd_pkg::div_65535(a_tprod_reg);
    assign hq = hfd_pkg::div_65535(hfd_pkg::TPROD_W'(a_hprod_reg));

    always_comb begin
        temp_next = temp_reg;
        hum_next  = hum_reg;
        if (out_load && a_rec_reg.good) begin
            temp_next = tq - hfd_pkg::TEMP_OFFSET;
            hum_next  = hq[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            a_rec_reg   <= rec;
            a_tprod_reg <= hfd_pkg::TPROD_W'(rec.temperature_code)
                         * hfd_pkg::TPROD_W'(hfd_pkg::TEMP_SCALE);
            a_hprod_reg <= hfd_pkg::HPROD_W'(rec.humidity_code)
                         * hfd_pkg::HPROD_W'(hfd_pkg::HUM_SCALE);
        end
        if (out_load) begin
            status_reg <= !a_rec_reg.good;
            tcode_reg  <= a_rec_reg.temperature_code;
            hcode_reg  <= a_rec_reg.humidity_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            temp_reg    <= '0;
            hum_reg     <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, hcode_reg, tcode_reg, hum_reg, temp_reg, status_reg};

endmodule

>>> verif/frame_reading_checker.sv
// Checker for the frame decoder: predicts each reading from the received bytes and compares.
module frame_reading_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [0] status, [18:1] temperature_milli_c,
                                   // [35:19] humidity_milli_pct, [51:36] temperature_code,
                                   // [67:52] humidity_code, [71:68] zero
    output int          outstanding,
    output int          mismatches
);

    localparam logic STATUS_GOOD    = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;
    localparam logic [7:0] CRC_SEED = 8'hFF;
    localparam logic [7:0] GEN_POLY = 8'h31;

    typedef struct packed {
        logic               status;
        logic signed [17:0] temperature_milli_c;
        logic [16:0]        humidity_milli_pct;
        logic [15:0]        temperature_code;
        logic [15:0]        humidity_code;
    } reading_t;

    reading_t    awaited_readings[$];

    logic [2:0]  frame_pos     = hfd_pkg::POS_T_HI;
    logic [7:0]  word_crc      = CRC_SEED;
    logic [15:0] word_shift    = '0;
    logic [15:0] temp_word     = '0;
    logic        temp_crc_ok   = 1'b0;
    logic [17:0] good_temp     = '0;
    logic [16:0] good_hum      = '0;

    initial begin
        outstanding = 0;
        mismatches  = 0;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] octet);
        logic [7:0] c;
        c = crc ^ octet;
        repeat (8) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ GEN_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic advance_frame(input logic [7:0] octet, input logic first);
        reading_t    r;
        logic        ok;
        logic [63:0] scaled;
        if (first || frame_pos > hfd_pkg::POS_H_CRC) begin
            frame_pos = hfd_pkg::POS_T_HI;
        end
        case (frame_pos)
            hfd_pkg::POS_T_HI, hfd_pkg::POS_H_HI: begin
                word_crc   = crc8_step(CRC_SEED, octet);
                word_shift = {octet, 8'h00};
            end
            hfd_pkg::POS_T_LO, hfd_pkg::POS_H_LO: begin
                word_crc   = crc8_step(word_crc, octet);
                word_shift = {word_shift[15:8], octet};
            end
            hfd_pkg::POS_T_CRC: begin
                temp_crc_ok = (word_crc == octet);
                temp_word   = word_shift;
                word_crc    = CRC_SEED;
            end
            default: begin
                ok = temp_crc_ok && (word_crc == octet);
                if (ok) begin
                    scaled    = (64'd175000 * 64'(temp_word)) / 64'd65535;
                    good_temp = 18'(scaled) - 18'd45000;
                    scaled    = (64'd100000 * 64'(word_shift)) / 64'd65535;
                    good_hum  = 17'(scaled);
                end
                r.status              = ok ? STATUS_GOOD : STATUS_CRC_ERR;
                r.temperature_milli_c = $signed(good_temp);
                r.humidity_milli_pct  = good_hum;
                r.temperature_code    = temp_word;
                r.humidity_code       = word_shift;
                awaited_readings.push_back(r);
                word_crc = CRC_SEED;
            end
        endcase
        frame_pos = (frame_pos == hfd_pkg::POS_H_CRC) ? hfd_pkg::POS_T_HI : frame_pos + 3'd1;
    endtask

    task automatic check_reading(input logic [71:0] d);
        reading_t want;
        if (awaited_readings.size() == 0) begin
            $error("reading arrived with no frame pending: %h", d);
            mismatches++;
        end else begin
            want = awaited_readings.pop_front();
            if (d[0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, d[0]);
                mismatches++;
            end
            if ($signed(d[18:1]) !== want.temperature_milli_c) begin
                $error("temperature_milli_c: expected %0d, got %0d",
                       want.temperature_milli_c, $signed(d[18:1]));
                mismatches++;
            end
            if (d[35:19] !== want.humidity_milli_pct) begin
                $error("humidity_milli_pct: expected %0d, got %0d",
                       want.humidity_milli_pct, d[35:19]);
                mismatches++;
            end
            if (d[51:36] !== want.temperature_code) begin
                $error("temperature_code: expected %h, got %h", want.temperature_code, d[51:36]);
                mismatches++;
            end
            if (d[67:52] !== want.humidity_code) begin
                $error("humidity_code: expected %h, got %h", want.humidity_code, d[67:52]);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos   = hfd_pkg::POS_T_HI;
            word_crc    = CRC_SEED;
            word_shift  = '0;
            temp_word   = '0;
            temp_crc_ok = 1'b0;
            good_temp   = '0;
            good_hum    = '0;
            awaited_readings.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_reading(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                advance_frame(s_tdata, s_tuser[0]);
            end
        end
        outstanding <= awaited_readings.size();
    end

endmodule

>>> verif/humidity_temp_frame_decoder_tb.sv
// Testbench top for the frame decoder: drives sensor frames, stalls the result side, gives the verdict.
module humidity_temp_frame_decoder_tb;

    localparam int BYTE_TARGET = 1900;
    localparam int QUIET_LIMIT = 4000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] rx_byte
    logic [0:0]  s_tuser  = '0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // [0] status, [18:1] temperature_milli_c,
                                   // [35:19] humidity_milli_pct, [51:36] temperature_code,
                                   // [67:52] humidity_code, [71:68] zero
    int          outstanding;
    int          mismatches;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    int          sink_hold = 0;
    logic        sink_calm = 1'b0;
    logic        src_calm  = 1'b0;

    always #5 aclk = ~aclk;

    humidity_temp_frame_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    frame_reading_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 99) < 25) begin
                sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("humidity_temp_frame_decoder_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] word_crc8(input logic [15:0] w);
        logic [7:0] c;
        c = 8'hFF ^ w[15:8];
        repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
        c = c ^ w[7:0];
        repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic logic [15:0] pick_code();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0:       v = 16'h0000;
                1:       v = 16'h0001;
                2:       v = 16'h7FFF;
                3:       v = 16'h8000;
                4:       v = 16'hFFFE;
                default: v = 16'hFFFF;
            endcase
        end
        return v;
    endfunction

    task automatic push_byte(input logic [7:0] octet, input logic first);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= octet;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        gap = 0;
        if (!src_calm && $urandom_range(0, 99) < 40) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // flip_at < 0 keeps the frame intact; cut < 6 truncates it
    task automatic send_frame(input logic [15:0] tcode, input logic [15:0] hcode,
                              input logic first, input int flip_at, input int cut);
        logic [7:0] f[6];
        f[0] = tcode[15:8];
        f[1] = tcode[7:0];
        f[2] = word_crc8(tcode);
        f[3] = hcode[15:8];
        f[4] = hcode[7:0];
        f[5] = word_crc8(hcode);
        if (flip_at >= 0) begin
            f[flip_at] = f[flip_at] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < cut; i++) begin
            push_byte(f[i], (i == 0) ? first : 1'b0);
        end
    endtask

    task automatic drain_readings();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        int kind;
        int phase;
        int last_phase;
        last_phase = -1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame(16'h0000, 16'h0000, 1'b1, -1, 6);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, -1, 6);
        send_frame(16'h1234, 16'h5678, 1'b1, -1, 3);
        send_frame(16'h6666, 16'hABCD, 1'b1, 5, 6);
        drain_readings();

        while (bytes_sent < BYTE_TARGET) begin
            phase = bytes_sent / 200;
            if (phase != last_phase) begin
                last_phase = phase;
                src_calm   = ($urandom_range(0, 99) < 30);
                sink_calm <= ($urandom_range(0, 99) < 30);
                if (phase == 4) begin
                    drain_readings();
                end
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(pick_code(), pick_code(), ($urandom_range(0, 4) != 0),
                           ($urandom_range(0, 99) < 15) ? $urandom_range(0, 5) : -1, 6);
            end else if (kind < 85) begin
                send_frame(pick_code(), pick_code(), 1'b1, -1, $urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom), 1'($urandom));
            end
        end

        drain_readings();
        repeat (12) @(posedge aclk);
        if (mismatches == 0) begin
            $display("humidity_temp_frame_decoder_tb OK");
        end else begin
            $display("humidity_temp_frame_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
